// ----- src/spq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by every module of the block.
package spq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int OCC_W = 5;
	localparam int ID_W  = 16;
	localparam int LVL_W = 8;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_POPPED   = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_POP    = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [LVL_W-1:0] level;
	} entry_t;

	// broadcast to every cell in the chain
	typedef struct packed {
		logic   ins;
		logic   pop;
		entry_t ent;
	} cell_ctrl_t;

endpackage

// ----- src/spq_cell.sv -----
`timescale 1ns / 1ps
// One slot of the sorted chain: holds an entry and shifts toward head or tail.
// Depends on spq_pkg.
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic               occupied,
	input  logic               prev_keep,
	input  spq_pkg::entry_t    prev_ent,
	input  spq_pkg::entry_t    next_ent,
	output logic               keep,
	output spq_pkg::entry_t    ent_q
);
	import spq_pkg::*;

	// stays put on insert: occupied and not outranked (ties go behind)
	assign keep = occupied && (ent_q.level >= ctrl.ent.level);

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (!keep) begin
				ent_q <= prev_keep ? ctrl.ent : prev_ent;
			end
		end else if (ctrl.pop) begin
			ent_q <= next_ent;
		end
	end

endmodule

// ----- src/sorted_priority_queue.sv -----
`timescale 1ns / 1ps
// Sorted priority queue built as a chain of DEPTH compare-and-shift cells.
// The response is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle while req_stall is low; the cells finish insert or pop on the accepting edge.
// A waiting response that is stalled holds off the next request (req_stall).
// Reset (arst_n low) empties the queue and drops any pending response.
module sorted_priority_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic                    req_type,
	input  logic [spq_pkg::ID_W-1:0]  entry_id,
	input  logic [spq_pkg::LVL_W-1:0] entry_level,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic [1:0]              status,
	output logic [spq_pkg::ID_W-1:0]  out_id,
	output logic [spq_pkg::LVL_W-1:0] out_level,
	output logic [spq_pkg::OCC_W-1:0] occupancy
);
	import spq_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             accept;
	logic             full;
	logic             empty;
	cell_ctrl_t       ctrl;
	status_t          status_nxt;
	status_t          status_q;
	entry_t           rsp_ent_q;
	entry_t           rsp_ent_nxt;
	logic [OCC_W-1:0] occ_q;
	logic             rsp_valid_q;

	entry_t           ent   [DEPTH];
	logic             keep  [DEPTH];
	logic [DEPTH-1:0] occupied;

	// a response waiting on a stalled consumer blocks new requests
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);

	// broadcast control: the new entry and which shift to perform
	always_comb begin
		ctrl.ent.id    = entry_id;
		ctrl.ent.level = entry_level;
		ctrl.ins       = accept && (req_type == REQ_INSERT) && !full;
		ctrl.pop       = accept && (req_type == REQ_POP) && !empty;
	end

	// response fields and next fill count
	always_comb begin
		count_nxt   = count_q;
		rsp_ent_nxt = '0;
		priority if (req_type == REQ_INSERT) begin
			if (full) begin
				status_nxt = ST_FULL;
			end else begin
				status_nxt = ST_INSERTED;
				count_nxt  = count_q + 1'b1;
			end
		end else begin
			if (empty) begin
				status_nxt = ST_EMPTY;
			end else begin
				status_nxt  = ST_POPPED;
				rsp_ent_nxt = ent[0];
				count_nxt   = count_q - 1'b1;
			end
		end
	end

	// chain of cells; slot 0 is the head
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t prev_ent;
		entry_t next_ent;
		logic   prev_keep;

		assign occupied[i] = (count_q > CNT_W'(i));

		if (i == 0) begin : g_head
			assign prev_ent  = ctrl.ent;
			assign prev_keep = 1'b1;
		end else begin : g_body
			assign prev_ent  = ent[i-1];
			assign prev_keep = keep[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_ent = ent[i];
		end else begin : g_inner
			assign next_ent = ent[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occupied  (occupied[i]),
			.prev_keep (prev_keep),
			.prev_ent  (prev_ent),
			.next_ent  (next_ent),
			.keep      (keep[i]),
			.ent_q     (ent[i])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload, loaded only on an accepted request
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= status_nxt;
			rsp_ent_q <= rsp_ent_nxt;
			occ_q     <= OCC_W'(count_nxt);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign out_id    = rsp_ent_q.id;
	assign out_level = rsp_ent_q.level;
	assign occupancy = occ_q;

endmodule

// ----- src/spq_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for sorted_priority_queue, bound onto the top level.
// Depends on spq_pkg.
module spq_checker (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	input  logic                    req_stall,
	input  logic                    req_type,
	input  logic [spq_pkg::ID_W-1:0]  entry_id,
	input  logic [spq_pkg::LVL_W-1:0] entry_level,
	input  logic                    rsp_valid,
	input  logic                    rsp_stall,
	input  logic [1:0]              status,
	input  logic [spq_pkg::ID_W-1:0]  out_id,
	input  logic [spq_pkg::LVL_W-1:0] out_level,
	input  logic [spq_pkg::OCC_W-1:0] occupancy
);
	import spq_pkg::*;

	// every accepted request yields a response in the next cycle
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> rsp_valid)
		else $error("no response after accepted request");

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(status) &&
			$stable(out_id) && $stable(out_level) && $stable(occupancy)))
		else $error("stalled response changed");

	// empty pop reports nothing held and no entry
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == ST_EMPTY) |->
			(occupancy == '0 && out_id == '0 && out_level == '0))
		else $error("empty response inconsistent");

	// full insert reports the queue at capacity
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == ST_FULL) |->
			(occupancy == OCC_W'(DEPTH) && out_id == '0 && out_level == '0))
		else $error("full response inconsistent");

	// a stall is only raised behind a pending response
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (rsp_valid && rsp_stall))
		else $error("request stalled without pending response");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

// ----- tb/sorted_priority_queue_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_queue: directed and random insert/pop traffic
// with bursty requests and random response stalls, checked against a local queue model.
// Depends on spq_pkg and the sorted_priority_queue RTL only.
module sorted_priority_queue_test;
	import spq_pkg::*;

	localparam int RANDOM_REQUESTS = 1650;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int MAX_REPORTS     = 10;

	typedef struct {
		req_kind_t        kind;
		logic [ID_W-1:0]  id;
		logic [LVL_W-1:0] level;
	} spq_request_t;

	typedef struct {
		status_t          st;
		logic [ID_W-1:0]  id;
		logic [LVL_W-1:0] level;
		logic [OCC_W-1:0] occ;
	} spq_response_t;

	// receiver stall styles, each held for a random stretch of cycles
	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             req_valid   = 1'b0;
	logic             req_stall;
	logic             req_type    = REQ_INSERT;
	logic [ID_W-1:0]  entry_id    = '0;
	logic [LVL_W-1:0] entry_level = '0;
	logic             rsp_valid;
	logic             rsp_stall   = 1'b0;
	logic [1:0]       status;
	logic [ID_W-1:0]  out_id;
	logic [LVL_W-1:0] out_level;
	logic [OCC_W-1:0] occupancy;

	sorted_priority_queue u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.entry_id    (entry_id),
		.entry_level (entry_level),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.out_id      (out_id),
		.out_level   (out_level),
		.occupancy   (occupancy)
	);

	always #2 clk = ~clk;

	// Requests waiting to be driven, and responses the queue model says must come back.
	spq_request_t  pending_requests[$];
	spq_response_t expected_responses[$];
	int            response_errors = 0;

	// Queue model: slot 0 is the head, only slots below queue_fill hold entries.
	entry_t        queue_slots[DEPTH];
	int            queue_fill = 0;

	// Apply one accepted request to the queue model and record the response it must give.
	task automatic predict_response(input req_kind_t kind, input logic [ID_W-1:0] id,
			input logic [LVL_W-1:0] level);
		spq_response_t rsp;
		int            pos;
		int            i;
		rsp.id    = '0;
		rsp.level = '0;
		if (kind == REQ_INSERT) begin
			if (queue_fill >= DEPTH) begin
				rsp.st = ST_FULL;
			end else begin
				// new entry goes behind every entry of equal or higher level
				pos = 0;
				while (pos < queue_fill && queue_slots[pos].level >= level)
					pos++;
				for (i = queue_fill; i > pos; i--)
					queue_slots[i] = queue_slots[i - 1];
				queue_slots[pos].id    = id;
				queue_slots[pos].level = level;
				queue_fill++;
				rsp.st = ST_INSERTED;
			end
		end else begin
			if (queue_fill == 0) begin
				rsp.st = ST_EMPTY;
			end else begin
				rsp.id    = queue_slots[0].id;
				rsp.level = queue_slots[0].level;
				for (i = 1; i < queue_fill; i++)
					queue_slots[i - 1] = queue_slots[i];
				queue_fill--;
				rsp.st = ST_POPPED;
			end
		end
		rsp.occ = OCC_W'(queue_fill);
		expected_responses = {expected_responses, rsp};
	endtask

	task automatic queue_insert(input logic [ID_W-1:0] id, input logic [LVL_W-1:0] level);
		spq_request_t req;
		req.kind  = REQ_INSERT;
		req.id    = id;
		req.level = level;
		pending_requests = {pending_requests, req};
	endtask

	// pop payload is don't-care; randomize it so the ignored fields still toggle
	task automatic queue_pop();
		spq_request_t req;
		req.kind  = REQ_POP;
		req.id    = ID_W'($urandom);
		req.level = LVL_W'($urandom);
		pending_requests = {pending_requests, req};
	endtask

	function automatic bit all_drained();
		return pending_requests.size() == 0 && !req_valid && expected_responses.size() == 0;
	endfunction

	// Request driver: bursts of random length separated by random gaps.
	// The payload is held until the queue takes it; prediction happens at acceptance.
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk) begin : drive_requests
		spq_request_t nxt;
		logic         taken;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			taken = req_valid && !req_stall;
			if (taken)
				predict_response(req_kind_t'(req_type), entry_id, entry_level);
			if (!req_valid || taken) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					nxt = pending_requests.pop_front();
					req_valid   <= 1'b1;
					req_type    <= nxt.kind;
					entry_id    <= nxt.id;
					entry_level <= nxt.level;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						// a quarter of bursts run straight into the next one
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response stall: switches between styles at random intervals, including stretches
	// with no stall at all.
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;

	always @(posedge clk) begin : drive_rsp_stall
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(16, 160);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			STALL_NONE: begin
				rsp_stall <= 1'b0;
			end
			STALL_LIGHT: begin
				rsp_stall <= ($urandom_range(0, 3) == 0);
			end
			STALL_HEAVY: begin
				rsp_stall <= ($urandom_range(0, 9) < 7);
			end
			default: begin
				rsp_stall <= (stall_left % 8) < 3;
			end
		endcase
	end

	// Response monitor: every accepted response must match the oldest prediction.
	always @(posedge clk) begin : check_responses
		spq_response_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_responses.size() == 0) begin
				response_errors++;
				if (response_errors <= MAX_REPORTS)
					$display("unexpected response at %0t: status %0d id %h level %h occ %0d",
						$time, status, out_id, out_level, occupancy);
			end else begin
				want = expected_responses.pop_front();
				if (status !== want.st || out_id !== want.id || out_level !== want.level ||
						occupancy !== want.occ) begin
					response_errors++;
					if (response_errors <= MAX_REPORTS) begin
						$write("response mismatch at %0t: expected status %0d id %h ",
							$time, want.st, want.id);
						$display("level %h occ %0d, got status %0d id %h level %h occ %0d",
							want.level, want.occ, status, out_id, out_level, occupancy);
					end
				end
			end
		end
	end

	initial begin : run_test
		logic [LVL_W-1:0] fill_levels[8];
		logic [LVL_W-1:0] level_base;
		int               insert_pct;
		int               seg_len;
		int               generated;
		int               waited;
		int               k;
		bit               narrow_levels;
		bit               timed_out;

		fill_levels = '{8'h80, 8'hFF, 8'h00, 8'h7F, 8'h81, 8'h80, 8'hFF, 8'h00};

		// Directed: pop on empty, field extremes, equal-level ties, fill to full,
		// insert on full, then pops that must come out in level/arrival order.
		queue_pop();
		queue_insert(16'hFFFF, 8'hFF);
		queue_insert(16'h0000, 8'h00);
		queue_insert(16'h0101, 8'h80);
		queue_insert(16'h0202, 8'h80);
		queue_insert(16'h0303, 8'h80);
		for (k = 0; k < DEPTH - 5; k++)
			queue_insert(ID_W'(16'h1000 + k), fill_levels[k % 8]);
		queue_insert(16'hBEEF, 8'hC0);
		queue_pop();
		queue_pop();
		queue_pop();

		// Random: segments that lean toward filling or draining so both full and empty
		// are hit often; some segments use a narrow level band to force many ties.
		generated = 0;
		while (generated < RANDOM_REQUESTS) begin
			seg_len = $urandom_range(20, 120);
			case ($urandom_range(0, 4))
				0:       insert_pct = 85;
				1:       insert_pct = 65;
				2:       insert_pct = 50;
				3:       insert_pct = 35;
				default: insert_pct = 15;
			endcase
			narrow_levels = $urandom_range(0, 1);
			level_base    = LVL_W'($urandom_range(0, 252));
			repeat (seg_len) begin
				if ($urandom_range(0, 99) < insert_pct) begin
					if (narrow_levels)
						queue_insert(ID_W'($urandom),
							level_base + LVL_W'($urandom_range(0, 3)));
					else if ($urandom_range(0, 15) == 0)
						queue_insert(ID_W'($urandom), $urandom_range(0, 1) ? 8'hFF : 8'h00);
					else
						queue_insert(ID_W'($urandom), LVL_W'($urandom));
				end else begin
					queue_pop();
				end
				generated++;
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Drain check sits on the falling edge, away from the driver and monitor updates.
		waited = 0;
		while (!all_drained() && waited < CYCLE_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		timed_out = !all_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (timed_out || response_errors != 0 || expected_responses.size() != 0)
			$display("sorted_priority_queue_test failed");
		else
			$display("sorted_priority_queue_test passed");
		$finish;
	end

endmodule

// ----- files.f -----
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
src/spq_checker.sv
tb/sorted_priority_queue_test.sv
